>>> sv/ccc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccc_pkg
// shared types, limits and the month-length table of the calendar clock
// ----------------------------------------------------------------------------
package ccc_pkg;

    // sub-second ticks in one second
    localparam int TICKS_PER_SECOND = 100;
    localparam int TICK_W           = (TICKS_PER_SECOND > 2) ? $clog2(TICKS_PER_SECOND) : 1;

    localparam logic [TICK_W-1:0] TICK_LAST  = TICK_W'(TICKS_PER_SECOND - 1);
    localparam logic [5:0]        SEC_LAST   = 6'd59;
    localparam logic [5:0]        MIN_LAST   = 6'd59;
    localparam logic [4:0]        HOUR_LAST  = 5'd23;
    localparam logic [4:0]        LEAP_DAY   = 5'd29;
    localparam logic [3:0]        MONTH_FEB  = 4'd2;
    localparam logic [3:0]        MONTH_MAR  = 4'd3;
    localparam logic [3:0]        MONTH_LAST = 4'd12;
    localparam logic [6:0]        YEAR_LAST  = 7'd99;

    // reset date
    localparam logic [4:0] DAY_RESET   = 5'd7;
    localparam logic [3:0] MONTH_RESET = 4'd8;
    localparam logic [6:0] YEAR_RESET  = 7'd11;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_LOAD_TIME = 2'd1,
        OP_LOAD_DATE = 2'd2
    } op_t;

    typedef struct packed {
        logic sec;
        logic min;
        logic date;
    } chg_flags_t;

    // days in a month; invalid month codes count as 31 days
    function automatic logic [4:0] month_length(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                      len = 5'd29;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> sv/calendar_clock_counter.sv
`timescale 1ns / 1ps
// path: the input register, then the time/date registers, which double as the
// result register, with a single pass of compare/increment logic between them
// throughput: one word per cycle unless the result register is held by out_stall
// reset: time clears to 00:00:00, date goes to day 7, month 8, year 11, sub-second
// count to 0; both stages come up empty
// ----------------------------------------------------------------------------
// calendar_clock_counter
// real-time clock and calendar: hundredth-second ticks advance a cascade
// through seconds, minutes, hours, day, month and two-digit year; load words
// overwrite the time or the date
// ----------------------------------------------------------------------------
module calendar_clock_counter (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [4:0] new_hour,
    input  logic [5:0] new_minute,
    input  logic [5:0] new_second,
    input  logic [4:0] new_day,
    input  logic [3:0] new_month,
    input  logic [6:0] new_year,
    // result channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [4:0] hour,
    output logic [5:0] minute,
    output logic [5:0] second,
    output logic [4:0] day,
    output logic [3:0] month,
    output logic [6:0] year,
    output logic       second_changed,
    output logic       minute_changed,
    output logic       date_changed
);
    import ccc_pkg::*;

    // input register stage
    logic       in_valid_reg;
    logic [1:0] opcode_reg;
    logic [4:0] new_hour_reg;
    logic [5:0] new_minute_reg;
    logic [5:0] new_second_reg;
    logic [4:0] new_day_reg;
    logic [3:0] new_month_reg;
    logic [6:0] new_year_reg;

    // clock/calendar state; it also serves as the result payload, since it is
    // only written when the result register is free to take a new word
    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [5:0]        seconds_reg,    seconds_next;
    logic [5:0]        minutes_reg,    minutes_next;
    logic [4:0]        hours_reg,      hours_next;
    logic [4:0]        day_reg,        day_next;
    logic [3:0]        month_reg,      month_next;
    logic [6:0]        year_reg,       year_next;

    // result stage
    logic       out_valid_reg;
    chg_flags_t flags_reg, flags_next;

    logic out_free;   // result register can take a word this cycle
    logic advance;    // input register word moves into the result stage

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    // input register holds a word that cannot move on
    assign in_stall = in_valid_reg && !out_free;

    // single pass: tick cascade or load, from the input register and state
    always_comb
    begin
        logic [4:0] len;
        logic [4:0] day_inc;

        tick_count_next = tick_count_reg;
        seconds_next    = seconds_reg;
        minutes_next    = minutes_reg;
        hours_next      = hours_reg;
        day_next        = day_reg;
        month_next      = month_reg;
        year_next       = year_reg;
        flags_next      = '0;
        len             = month_length(month_reg);
        day_inc         = day_reg + 5'd1;

        unique case (opcode_reg)
            OP_TICK:
            begin
                if (tick_count_reg < TICK_LAST)
                begin
                    tick_count_next = tick_count_reg + TICK_W'(1);
                end
                else
                begin
                    tick_count_next = '0;
                    flags_next.sec  = 1'b1;
                    // out-of-range counts behave as the last value
                    if (seconds_reg < SEC_LAST)
                    begin
                        seconds_next = seconds_reg + 6'd1;
                    end
                    else
                    begin
                        seconds_next   = '0;
                        flags_next.min = 1'b1;
                        if (minutes_reg < MIN_LAST)
                        begin
                            minutes_next = minutes_reg + 6'd1;
                        end
                        else
                        begin
                            minutes_next = '0;
                            if (hours_reg < HOUR_LAST)
                            begin
                                hours_next = hours_reg + 5'd1;
                            end
                            else
                            begin
                                hours_next      = '0;
                                flags_next.date = 1'b1;
                                if (day_reg < len)
                                begin
                                    // february 29 only in years divisible by four
                                    if (day_inc == LEAP_DAY && month_reg == MONTH_FEB &&
                                        year_reg[1:0] != 2'd0)
                                    begin
                                        day_next   = 5'd1;
                                        month_next = MONTH_MAR;
                                    end
                                    else
                                    begin
                                        day_next = day_inc;
                                    end
                                end
                                else
                                begin
                                    day_next = 5'd1;
                                    if (month_reg < MONTH_LAST)
                                    begin
                                        month_next = month_reg + 4'd1;
                                    end
                                    else
                                    begin
                                        month_next = 4'd1;
                                        year_next  = (year_reg < YEAR_LAST) ?
                                                     year_reg + 7'd1 : 7'd0;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            OP_LOAD_TIME:
            begin
                hours_next   = new_hour_reg;
                minutes_next = new_minute_reg;
                seconds_next = new_second_reg;
            end
            OP_LOAD_DATE:
            begin
                day_next   = new_day_reg;
                month_next = new_month_reg;
                year_next  = new_year_reg;
            end
            default:
            begin
                // unused code: no change, flags clear
                flags_next = '0;
            end
        endcase
    end

    // input register: payload has no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            opcode_reg     <= opcode;
            new_hour_reg   <= new_hour;
            new_minute_reg <= new_minute;
            new_second_reg <= new_second;
            new_day_reg    <= new_day;
            new_month_reg  <= new_month;
            new_year_reg   <= new_year;
        end
    end

    // state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            flags_reg      <= '0;
            tick_count_reg <= '0;
            seconds_reg    <= '0;
            minutes_reg    <= '0;
            hours_reg      <= '0;
            day_reg        <= DAY_RESET;
            month_reg      <= MONTH_RESET;
            year_reg       <= YEAR_RESET;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                flags_reg      <= flags_next;
                tick_count_reg <= tick_count_next;
                seconds_reg    <= seconds_next;
                minutes_reg    <= minutes_next;
                hours_reg      <= hours_next;
                day_reg        <= day_next;
                month_reg      <= month_next;
                year_reg       <= year_next;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign hour           = hours_reg;
    assign minute         = minutes_reg;
    assign second         = seconds_reg;
    assign day            = day_reg;
    assign month          = month_reg;
    assign year           = year_reg;
    assign second_changed = flags_reg.sec;
    assign minute_changed = flags_reg.min;
    assign date_changed   = flags_reg.date;

`ifndef SYNTHESIS
    // change flags cascade: a date change implies minute and second changes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!date_changed || minute_changed) && (!minute_changed || second_changed))
    else $error("change flags out of cascade order");

    // a minute change always leaves the seconds at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && minute_changed |-> second == 6'd0)
    else $error("minute change with nonzero seconds");

    // a date change happens only at midnight
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && date_changed |-> hour == 5'd0 && minute == 6'd0)
    else $error("date change away from midnight");

    // input side stalls only behind a full, stalled result register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
    else $error("input stalled without result backpressure");
`endif

endmodule
